/* sv/sfp16_pkg.sv */
`default_nettype none
package sfp16_pkg;
  localparam logic [15:0] NAN_CODE = 16'h7f01;
  localparam logic [15:0] POS_INF = 16'h7f00;
  localparam logic [15:0] NEG_INF = 16'hff00;
  localparam logic [6:0] EXP_MAX = 7'd127;
endpackage
`default_nettype wire

/* sv/sfp16_lzc.sv */
`default_nettype none
module sfp16_lzc
  import sfp16_pkg::*;
(
  input  wire logic [12:0] value,
  output logic [3:0]       count
);
  always_comb begin
    count = 4'd13;
    for (int i = 0; i < 13; i++) begin
      if (value[i]) begin
        count = 4'(12 - i);
      end
    end
  end
endmodule
`default_nettype wire

/* sv/sfp16_adder.sv */
`default_nettype none
// Four-stage pipelined adder for 1-7-8 floats. A word is accepted every
// cycle (busy stays low); its sum appears on out_sum_value with out_valid
// once it has passed the stage 1, 2 and 3 registers. The result register
// cannot be stalled.
module sfp16_adder
  import sfp16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  output logic             out_valid,
  output logic [15:0]      out_sum_value
);
  assign busy = 1'b0;

  logic [3:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
  end

  // stage 1: order, unpack, special detect
  logic [15:0] a, b;
  logic        sp1_nxt;
  logic [15:0] spv1_nxt;
  always_comb begin
    if (in_operand_a[14:0] < in_operand_b[14:0]) begin
      a = in_operand_b; b = in_operand_a;
    end else begin
      a = in_operand_a; b = in_operand_b;
    end
    sp1_nxt = 1'b0;
    spv1_nxt = a;
    if ((a[14:8] == EXP_MAX && a[7:0] != 0) || (b[14:8] == EXP_MAX && b[7:0] != 0)) begin
      sp1_nxt = 1'b1; spv1_nxt = NAN_CODE;
    end else if (a[14:8] == EXP_MAX) begin
      sp1_nxt = 1'b1;
      spv1_nxt = (b[14:8] == EXP_MAX && a[15] != b[15]) ? NAN_CODE : a;
    end
  end
  logic        sp1_r, sa1_r, sub1_r;
  logic [15:0] spv1_r;
  logic [6:0]  e1_r, d1_r;
  logic [8:0]  ma1_r, mb1_r;
  always_ff @(posedge clk) begin
    sp1_r <= sp1_nxt;
    spv1_r <= spv1_nxt;
    sa1_r <= a[15];
    sub1_r <= a[15] ^ b[15];
    ma1_r <= {a[14:8] != 0, a[7:0]};
    mb1_r <= {b[14:8] != 0, b[7:0]};
    e1_r <= (a[14:8] != 0) ? a[14:8] : 7'd1;
    d1_r <= ((a[14:8] != 0) ? a[14:8] : 7'd1) - ((b[14:8] != 0) ? b[14:8] : 7'd1);
  end

  // stage 2: align and add or subtract
  logic [11:0] wb;
  logic [12:0] w2_nxt;
  logic [35:0] sh;
  always_comb begin
    sh = {mb1_r, 3'b000, 24'd0} >> d1_r;
    if (d1_r >= 7'd24) begin
      wb = {11'd0, mb1_r != 0};
    end else begin
      wb = sh[35:24] | {11'd0, sh[23:0] != 0};
    end
    w2_nxt = sub1_r ? ({1'b0, ma1_r, 3'b000} - {1'b0, wb})
                    : ({1'b0, ma1_r, 3'b000} + {1'b0, wb});
  end
  logic        sp2_r, sa2_r;
  logic [15:0] spv2_r;
  logic [6:0]  e2_r;
  logic [12:0] w2_r;
  always_ff @(posedge clk) begin
    sp2_r <= sp1_r; spv2_r <= spv1_r; sa2_r <= sa1_r; e2_r <= e1_r; w2_r <= w2_nxt;
  end

  // stage 3: normalize
  logic [3:0]  lz;
  logic [3:0]  sl;
  logic [11:0] w3_nxt;
  logic [7:0]  e3_nxt;
  sfp16_lzc u_lzc (.value(w2_r), .count(lz));
  always_comb begin
    sl = '0;
    if (w2_r[12]) begin
      w3_nxt = w2_r[12:1] | {11'd0, w2_r[0]};
      e3_nxt = {1'b0, e2_r} + 8'd1;
    end else begin
      if (lz > 4'd1) begin
        sl = ({3'd0, lz - 4'd1} > {1'b0, e2_r} - 8'd1) ? 4'(e2_r - 7'd1) : lz - 4'd1;
      end
      w3_nxt = w2_r[11:0] << sl;
      e3_nxt = {1'b0, e2_r} - {4'd0, sl};
    end
  end
  logic        sp3_r, sa3_r;
  logic [15:0] spv3_r;
  logic [7:0]  e3_r;
  logic [11:0] w3_r;
  always_ff @(posedge clk) begin
    sp3_r <= sp2_r; spv3_r <= spv2_r; sa3_r <= sa2_r; e3_r <= e3_nxt; w3_r <= w3_nxt;
  end

  // stage 4: round and pack
  logic [9:0]  sig;
  logic [7:0]  ex;
  logic [15:0] res_nxt;
  always_comb begin
    sig = {1'b0, w3_r[11:3]};
    if (w3_r[2] && (w3_r[1:0] != 0 || w3_r[3])) begin
      sig = sig + 10'd1;
    end
    ex = e3_r;
    if (sig[9]) begin
      sig = sig >> 1;
      ex = ex + 8'd1;
    end
    if (sp3_r) begin
      res_nxt = spv3_r;
    end else if (ex >= {1'b0, EXP_MAX}) begin
      res_nxt = sa3_r ? NEG_INF : POS_INF;
    end else if (sig[8]) begin
      res_nxt = {sa3_r, ex[6:0], sig[7:0]};
    end else begin
      res_nxt = {sa3_r, 7'd0, sig[7:0]};
    end
  end
  always_ff @(posedge clk) begin
    out_sum_value <= res_nxt;
  end
  assign out_valid = v_r[3];
endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  import sfp16_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_operand_a = 16'h0000;
  logic [15:0] in_operand_b = 16'h0000;
  logic        out_valid;
  logic [15:0] out_sum_value;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED = 24;

  logic [15:0] pending_sums[$];
  int          errors = 0;
  int          idle_cycles = 0;

  logic [15:0] dir_a [N_DIRECTED];
  logic [15:0] dir_b [N_DIRECTED];
  logic [15:0] dir_sum [N_DIRECTED];
  logic        dir_known [N_DIRECTED];

  sfp16_adder DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_sum_value(out_sum_value)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] sticky_shift(logic [31:0] v, logic [31:0] n);
    logic [31:0] lost;
    if (n == 0) return v;
    if (n >= 24) return (v != 0) ? 32'd1 : 32'd0;
    lost = v & ((32'd1 << n) - 1);
    return (v >> n) | ((lost != 0) ? 32'd1 : 32'd0);
  endfunction

  function automatic logic [15:0] float_sum(logic [15:0] x, logic [15:0] y);
    logic [15:0] hi, lo;
    logic        s_hi, s_lo;
    logic [6:0]  e_hi, e_lo;
    logic [7:0]  f_hi, f_lo;
    logic [31:0] m_hi, m_lo, eb, es, acc, ex, mant;
    if (x[14:0] < y[14:0]) begin
      hi = y; lo = x;
    end else begin
      hi = x; lo = y;
    end
    s_hi = hi[15]; s_lo = lo[15];
    e_hi = hi[14:8]; e_lo = lo[14:8];
    f_hi = hi[7:0]; f_lo = lo[7:0];
    if ((e_hi == EXP_MAX && f_hi != 0) || (e_lo == EXP_MAX && f_lo != 0)) return NAN_CODE;
    if (e_hi == EXP_MAX) return (e_lo == EXP_MAX && s_hi != s_lo) ? NAN_CODE : hi;
    m_hi = {23'd0, e_hi != 0, f_hi};
    m_lo = {23'd0, e_lo != 0, f_lo};
    eb = (e_hi != 0) ? e_hi : 1;
    es = (e_lo != 0) ? e_lo : 1;
    acc = (s_hi == s_lo) ? (m_hi << 3) + sticky_shift(m_lo << 3, eb - es)
                         : (m_hi << 3) - sticky_shift(m_lo << 3, eb - es);
    ex = eb;
    if (acc >= 4096) begin
      acc = sticky_shift(acc, 1);
      ex++;
    end else begin
      while (acc < 2048 && ex > 1) begin
        acc = acc << 1;
        ex--;
      end
    end
    mant = acc >> 3;
    if (acc[2] && (acc[1:0] != 0 || mant[0])) mant++;
    if (mant >= 512) begin
      mant = mant >> 1;
      ex++;
    end
    if (ex >= EXP_MAX) return s_hi ? NEG_INF : POS_INF;
    if (mant >= 256) return {s_hi, ex[6:0], mant[7:0]};
    return {s_hi, 7'd0, mant[7:0]};
  endfunction

  task automatic set_row(int i, logic [15:0] a, logic [15:0] b, logic k, logic [15:0] s);
    dir_a[i] = a; dir_b[i] = b; dir_known[i] = k; dir_sum[i] = s;
  endtask

  task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] want, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    pending_sums.push_back(want);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum %h", $time, out_sum_value);
        errors++;
      end else begin
        if (pending_sums[0] !== out_sum_value) begin
          $display("%0t: sum expected %h actual %h", $time, pending_sums[0], out_sum_value);
          errors++;
        end
        void'(pending_sums.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [15:0] a, b, w;
    int          i;
    set_row(0, 16'h0000, 16'h0000, 1, 16'h0000);
    set_row(1, 16'h0000, 16'h8000, 1, 16'h0000);
    set_row(2, 16'h8000, 16'h0000, 1, 16'h8000);
    set_row(3, 16'h7f05, 16'h3f00, 1, NAN_CODE);
    set_row(4, 16'h3f00, 16'hff80, 1, NAN_CODE);
    set_row(5, 16'h7f00, 16'hff00, 1, NAN_CODE);
    set_row(6, 16'h7f00, 16'h7f00, 1, POS_INF);
    set_row(7, 16'hff00, 16'h3f00, 1, NEG_INF);
    set_row(8, 16'h7eff, 16'h7eff, 1, POS_INF);
    set_row(9, 16'hfeff, 16'hfeff, 1, NEG_INF);
    set_row(10, 16'h3f00, 16'hbf00, 1, 16'h0000);
    set_row(11, 16'hbf00, 16'h3f00, 1, 16'h8000);
    set_row(12, 16'h00ff, 16'h0001, 1, 16'h0100);
    set_row(13, 16'h0001, 16'h0001, 1, 16'h0002);
    set_row(14, 16'h0100, 16'h8001, 0, 0);
    set_row(15, 16'h3f01, 16'h3701, 0, 0);
    set_row(16, 16'h3f01, 16'h3680, 0, 0);
    set_row(17, 16'h3fff, 16'h3780, 0, 0);
    set_row(18, 16'h7eff, 16'h7680, 0, 0);
    set_row(19, 16'h3f00, 16'hbeff, 0, 0);
    set_row(20, 16'h0001, 16'h7e00, 0, 0);
    set_row(21, 16'hffff, 16'h0000, 1, NAN_CODE);
    set_row(22, 16'h4000, 16'hc0ff, 0, 0);
    set_row(23, 16'haaaa, 16'h5555, 0, 0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < N_DIRECTED; i++)
      send_word(dir_a[i], dir_b[i],
                dir_known[i] ? dir_sum[i] : float_sum(dir_a[i], dir_b[i]), 1'b0);
    for (i = 0; i < 1100; i++) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(3))
        0: b[14:8] = a[14:8] + 7'($urandom_range(4)) - 7'd2;
        1: b = {~a[15], a[14:0] ^ 15'($urandom_range(3))};
        default: ;
      endcase
      w = float_sum(a, b);
      send_word(a, b, w, (i < 300 || i > 500));
    end
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
